// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define FAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent is followed in the next cycle by the consequent
`define FAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/fab_pkg.sv -----
// ----------------------------------------------------------------------------
// fab_pkg
// types and constants of the frame bitmap allocator
// ----------------------------------------------------------------------------
package fab_pkg;

  localparam int FRAME_W     = 12;
  localparam int CNT_W       = 13;
  localparam int INDEX_LIMIT = 4096;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  localparam logic       REQ_ALLOC = 1'b0;
  localparam logic       REQ_FREE  = 1'b1;

  localparam logic [1:0] STATUS_CHANGED   = 2'd0;
  localparam logic [1:0] STATUS_NO_CHANGE = 2'd1;
  localparam logic [1:0] STATUS_NO_FREE   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_START,
    ST_ALLOC_CHK,
    ST_FREE_SEEK,
    ST_FREE_WR,
    ST_DONE
  } fab_state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               present;
    logic               writable;
    logic               user_mode;
    logic [1:0]         status;
  } fab_result_t;

endpackage

// ----- src/fab_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// fab_bitmap_ram
// used/free bitmap store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fab_bitmap_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/fab_word_scan.sv -----
// ----------------------------------------------------------------------------
// fab_word_scan
// finds the lowest free frame bit of one bitmap word inside the search window
// ----------------------------------------------------------------------------
module fab_word_scan #(
  parameter int WORD_BITS = 32,
  parameter int BW        = 5
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [WORD_BITS-1:0] window,
  output logic                 found,
  output logic [BW-1:0]        bit_idx
);

  logic [WORD_BITS-1:0] avail;

  assign avail = ~word & window;
  assign found = |avail;

  always_comb begin
    bit_idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        bit_idx = BW'(j);
      end
    end
  end

endmodule

// ----- src/frame_bitmap_allocator_unit.sv -----
// Frame bitmap allocator: first-fit page frame allocator over a used/free
// bitmap held in a single-port-write, registered-read memory of
// ceil(MAX_FRAMES / WORD_BITS) words. After reset a clearing pass writes one
// word per cycle while in_tready stays low. An allocation walks the bitmap
// one word per cycle through a shared base adder and compare; the number of
// words scanned is at most ceil(limit / WORD_BITS) (128 at defaults). A free
// steps the same adder to the frame's word and then reads and rewrites it.
// Requests that change nothing go straight to the result. One item is in
// work at a time; a finished result waits in the output register while the
// next item is accepted.
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_unit
// top level: sequencer, bitmap store and word scanner
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_bitmap_allocator_unit
  import fab_pkg::*;
#(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,    // frame_count
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,     // current_frame, kernel_page, write_allowed
  input  logic                  in_tuser,     // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata     // frame_index, present, writable,
                                              // user_mode, status
);

  localparam int WORDS    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW       = $clog2(WORD_BITS);
  localparam int LIMIT_FR = (MAX_FRAMES < INDEX_LIMIT) ? MAX_FRAMES : INDEX_LIMIT;

  fab_state_t         state_r, state_nxt;
  logic [AW-1:0]      word_r, word_nxt;
  logic [CNT_W-1:0]   base_r, base_nxt;
  logic [FRAME_W-1:0] cur_r, cur_nxt;
  logic               kern_r, kern_nxt;
  logic               wr_r, wr_nxt;
  fab_result_t        res_r, res_nxt;
  fab_result_t        out_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   frame_count_r;

  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     base_inc;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     cur_ext;
  logic [CNT_W-1:0]     free_off;
  logic [WORD_BITS-1:0] window;
  logic                 scan_found;
  logic [BW-1:0]        scan_idx;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  logic                 in_acc;
  logic                 out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  assign lim      = (frame_count_r > CNT_W'(LIMIT_FR)) ? CNT_W'(LIMIT_FR) : frame_count_r;
  assign base_inc = base_r + CNT_W'(WORD_BITS);
  assign rem      = lim - base_r;
  assign cur_ext  = {1'b0, cur_r};
  assign free_off = cur_ext - base_r;
  assign window   = (rem >= CNT_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                                               : ~({WORD_BITS{1'b1}} << rem[BW-1:0]);

  fab_bitmap_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fab_word_scan #(
    .WORD_BITS (WORD_BITS),
    .BW        (BW)
  ) u_scan (
    .word    (mem_rdata),
    .window  (window),
    .found   (scan_found),
    .bit_idx (scan_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      word_r        <= '0;
      out_valid_r   <= 1'b0;
      frame_count_r <= CNT_W'(INDEX_LIMIT);
    end else begin
      state_r <= state_nxt;
      word_r  <= word_nxt;
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    cur_r  <= cur_nxt;
    kern_r <= kern_nxt;
    wr_r   <= wr_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    word_nxt  = word_r;
    base_nxt  = base_r;
    cur_nxt   = cur_r;
    kern_nxt  = kern_r;
    wr_nxt    = wr_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = word_r;
    mem_raddr = word_r;
    mem_wdata = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (word_r == AW'(WORDS - 1)) begin
          word_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          cur_nxt  = in_tdata[FRAME_W-1:0];
          kern_nxt = in_tdata[FRAME_W];
          wr_nxt   = in_tdata[FRAME_W+1];
          word_nxt = '0;
          base_nxt = '0;
          res_nxt  = '0;
          if (in_tuser == REQ_ALLOC) begin
            if (in_tdata[FRAME_W-1:0] != '0) begin
              res_nxt.frame_index = in_tdata[FRAME_W-1:0];
              res_nxt.status      = STATUS_NO_CHANGE;
              state_nxt           = ST_DONE;
            end else begin
              state_nxt = ST_ALLOC_START;
            end
          end else begin
            if (in_tdata[FRAME_W-1:0] != '0) begin
              state_nxt = ST_FREE_SEEK;
            end else begin
              res_nxt.status = STATUS_NO_CHANGE;
              state_nxt      = ST_DONE;
            end
          end
        end
      end

      ST_ALLOC_START: begin
        if (lim == '0) begin
          res_nxt.status = STATUS_NO_FREE;
          state_nxt      = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_ALLOC_CHK;
        end
      end

      ST_ALLOC_CHK: begin
        if (scan_found) begin
          mem_we              = 1'b1;
          mem_wdata           = mem_rdata | (WORD_BITS'(1) << scan_idx);
          res_nxt.frame_index = base_r[FRAME_W-1:0] + FRAME_W'(scan_idx);
          res_nxt.present     = 1'b1;
          res_nxt.writable    = wr_r;
          res_nxt.user_mode   = !kern_r;
          res_nxt.status      = STATUS_CHANGED;
          state_nxt           = ST_DONE;
        end else if (base_inc < lim) begin
          mem_re    = 1'b1;
          mem_raddr = word_r + AW'(1);
          word_nxt  = word_r + AW'(1);
          base_nxt  = base_inc;
        end else begin
          res_nxt.status = STATUS_NO_FREE;
          state_nxt      = ST_DONE;
        end
      end

      ST_FREE_SEEK: begin
        if (cur_ext >= base_inc) begin
          if (word_r == AW'(WORDS - 1)) begin
            res_nxt.status = STATUS_CHANGED;
            state_nxt      = ST_DONE;
          end else begin
            word_nxt = word_r + AW'(1);
            base_nxt = base_inc;
          end
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_FREE_WR;
        end
      end

      ST_FREE_WR: begin
        mem_we         = 1'b1;
        mem_wdata      = mem_rdata & ~(WORD_BITS'(1) << free_off[BW-1:0]);
        res_nxt.status = STATUS_CHANGED;
        state_nxt      = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - FRAME_W - 5){1'b0}}, out_r.status, out_r.user_mode,
                       out_r.writable, out_r.present, out_r.frame_index};

  `FAB_ASSERT(a_mem_port_excl, !(mem_we && mem_re), "bitmap read and write in one cycle")
  `FAB_ASSERT(a_scan_in_window, (state_r != ST_ALLOC_CHK) || (base_r < lim),
              "scan word beyond limit")
  `FAB_ASSERT(a_alloc_below_lim,
              (state_r != ST_DONE) || !res_r.present || ({1'b0, res_r.frame_index} < lim),
              "frame at or above limit")
  `FAB_ASSERT_NEXT(a_load_from_done, !out_valid_r,
                   !out_valid_r || ($past(state_r) == ST_DONE),
                   "result shown without completion")

endmodule
